// ===== design/pbmc_pkg.sv =====
// shared types and constants of the pruning bound counter
`timescale 1ns / 1ps
package pbmc_pkg;

  localparam int SUM_W = 40;
  localparam int SQ_W  = 31;
  localparam int MAG_W = 17;
  localparam int POS_W = 9;
  localparam int CNT_W = 32;
  localparam int CL_W  = 9;
  localparam int IDX_W = 8;
  localparam int CRD_W = 16;
  localparam int EXT_W = 11;

  localparam logic [POS_W-1:0] POS_MAX  = 9'd511;
  localparam logic [CL_W-1:0]  CL_RESET = 9'd256;
  localparam logic [CNT_W-1:0] CNT_MAX  = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_COORD = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef struct packed {
    logic              valid;
    action_t           act;
    logic              last;
    logic              chk;
    logic [SQ_W-1:0]   sq;
    logic [SUM_W-1:0]  bound;
  } stage_t;

endpackage

// ===== design/pbmc_channels.sv =====
// handshake channel interfaces of the pruning bound counter
`timescale 1ns / 1ps
interface pbmc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [7:0]         bound_index;
  logic [39:0]        bound_value;
  logic signed [15:0] coordinate;
  logic               last_coordinate;
  modport source (output valid, action, bound_index, bound_value, coordinate,
                  last_coordinate, input ready);
  modport sink (input valid, action, bound_index, bound_value, coordinate,
                last_coordinate, output ready);
endinterface

interface pbmc_out_if;
  logic        valid;
  logic        ready;
  logic        vector_passed;
  logic [31:0] hit_count;
  logic [31:0] trial_count;
  modport source (output valid, vector_passed, hit_count, trial_count, input ready);
  modport sink (input valid, vector_passed, hit_count, trial_count, output ready);
endinterface

interface pbmc_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] check_length;
  modport source (output valid, check_length, input ready);
  modport sink (input valid, check_length, output ready);
endinterface

// ===== design/pbmc_ram.sv =====
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps
module pbmc_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/pbmc_front.sv =====
// position tracking, bound table access and coordinate squaring
`timescale 1ns / 1ps
module pbmc_front import pbmc_pkg::*; #(
  parameter int MAX_DIM = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       advance,
  input  logic                       accept,
  input  logic [1:0]                 action,
  input  logic [IDX_W-1:0]           bound_index,
  input  logic [SUM_W-1:0]           bound_value,
  input  logic signed [CRD_W-1:0]    coordinate,
  input  logic                       last_coordinate,
  input  logic [CL_W-1:0]            check_length,
  output logic                       ram_we,
  output logic [$clog2(MAX_DIM)-1:0] ram_waddr,
  output logic [SUM_W-1:0]           ram_wdata,
  output logic                       ram_re,
  output logic [$clog2(MAX_DIM)-1:0] ram_raddr,
  input  logic [SUM_W-1:0]           ram_rdata,
  output stage_t                     s2
);

  localparam int AW = $clog2(MAX_DIM);
  localparam logic [EXT_W-1:0] DIM_EXT = EXT_W'(MAX_DIM);

  action_t                  act_in;
  logic [EXT_W-1:0]         pos_ext;
  logic [EXT_W-1:0]         idx_ext;
  logic [POS_W-1:0]         position_r, position_nxt;
  logic                     s1_valid_r;
  action_t                  s1_act_r;
  logic                     s1_last_r;
  logic                     s1_chk_r;
  logic signed [CRD_W-1:0]  s1_crd_r;
  logic signed [MAG_W-1:0]  crd_ext;
  logic [MAG_W-1:0]         mag;
  logic [2*MAG_W-1:0]       prod;
  logic                     s2_valid_r;
  action_t                  s2_act_r;
  logic                     s2_last_r;
  logic                     s2_chk_r;
  logic [SQ_W-1:0]          s2_sq_r;
  logic [SUM_W-1:0]         s2_bound_r;
  logic                     chk;

  assign act_in  = action_t'(action);
  assign pos_ext = EXT_W'(position_r);
  assign idx_ext = EXT_W'(bound_index);
  assign chk     = (pos_ext < EXT_W'(check_length)) && (pos_ext < DIM_EXT);

  assign ram_we    = accept && (act_in == ACT_LOAD) && (idx_ext < DIM_EXT);
  assign ram_waddr = idx_ext[AW-1:0];
  assign ram_wdata = bound_value;
  assign ram_re    = accept && (act_in == ACT_COORD);
  assign ram_raddr = pos_ext[AW-1:0];

  always_comb begin
    position_nxt = position_r;
    if (accept && (act_in == ACT_COORD)) begin
      if (last_coordinate) begin
        position_nxt = '0;
      end else if (position_r != POS_MAX) begin
        position_nxt = position_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r <= '0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      position_r <= position_nxt;
      if (advance) begin
        s1_valid_r <= accept && ((act_in == ACT_COORD) || (act_in == ACT_CLEAR));
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_act_r   <= act_in;
      s1_last_r  <= last_coordinate;
      s1_chk_r   <= chk;
      s1_crd_r   <= coordinate;
      s2_act_r   <= s1_act_r;
      s2_last_r  <= s1_last_r;
      s2_chk_r   <= s1_chk_r;
      s2_sq_r    <= prod[SQ_W-1:0];
      s2_bound_r <= ram_rdata;
    end
  end

  // square of the magnitude, at most 2^30
  assign crd_ext = MAG_W'(s1_crd_r);
  assign mag     = crd_ext[MAG_W-1] ? MAG_W'(-crd_ext) : MAG_W'(crd_ext);
  assign prod    = mag * mag;

  assign s2 = {s2_valid_r, s2_act_r, s2_last_r, s2_chk_r, s2_sq_r, s2_bound_r};

endmodule

// ===== design/pbmc_accum.sv =====
// prefix sum, bound compare, counters and result register
`timescale 1ns / 1ps
module pbmc_accum import pbmc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  stage_t           s2,
  output logic             advance,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_passed,
  output logic [CNT_W-1:0] out_hits,
  output logic [CNT_W-1:0] out_trials
);

  logic [SUM_W-1:0] prefix_r, prefix_nxt;
  logic             failed_r, failed_nxt;
  logic [CNT_W-1:0] hits_r, hits_nxt;
  logic [CNT_W-1:0] trials_r, trials_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_passed_r;
  logic [CNT_W-1:0] out_hits_r, out_trials_r;
  logic [SUM_W:0]   sum_ext;
  logic [SUM_W-1:0] sum_new;
  logic             fail_new;
  logic             emit;
  logic             fire;

  assign sum_ext  = {1'b0, prefix_r} + (SUM_W+1)'(s2.sq);
  assign sum_new  = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
  assign fail_new = failed_r || (s2.chk && (sum_new > s2.bound));

  assign emit    = s2.valid && (s2.act == ACT_COORD) && s2.last;
  assign advance = !(emit && out_valid_r && !out_ready);
  assign fire    = s2.valid && advance;

  always_comb begin
    prefix_nxt    = prefix_r;
    failed_nxt    = failed_r;
    hits_nxt      = hits_r;
    trials_nxt    = trials_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (fire) begin
      case (s2.act)
        ACT_COORD: begin
          if (s2.last) begin
            prefix_nxt    = '0;
            failed_nxt    = 1'b0;
            out_valid_nxt = 1'b1;
            if (trials_r != CNT_MAX) begin
              trials_nxt = trials_r + CNT_W'(1);
            end
            if (!fail_new && (hits_r != CNT_MAX)) begin
              hits_nxt = hits_r + CNT_W'(1);
            end
          end else begin
            prefix_nxt = sum_new;
            failed_nxt = fail_new;
          end
        end
        ACT_CLEAR: begin
          hits_nxt   = '0;
          trials_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r    <= '0;
      failed_r    <= 1'b0;
      hits_r      <= '0;
      trials_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      prefix_r    <= prefix_nxt;
      failed_r    <= failed_nxt;
      hits_r      <= hits_nxt;
      trials_r    <= trials_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_passed_r <= !fail_new;
      out_hits_r   <= hits_nxt;
      out_trials_r <= trials_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_passed = out_passed_r;
  assign out_hits   = out_hits_r;
  assign out_trials = out_trials_r;

endmodule

// ===== design/pruning_bound_monte_carlo_counter_top.sv =====
// top level of the pruning bound monte carlo counter
//
//   channel  dir  carries
//   in_ch    in   action, bound_index, bound_value, coordinate, last_coordinate
//   out_ch   out  vector_passed, hit_count, trial_count
//   cfg_ch   in   check_length
//
// one item per cycle unless stalled; a result passes s1, s2, then the output register
// path: table read and square, then prefix add with bound compare in the same cycle
// rst_n clears position, sums, counters and check_length (256); table is not cleared
// input stalls only when a result reaches a full output register that is not taken
`timescale 1ns / 1ps
module pruning_bound_monte_carlo_counter_top import pbmc_pkg::*; #(
  parameter int MAX_DIM = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  pbmc_in_if.sink     in_ch,
  pbmc_out_if.source  out_ch,
  pbmc_cfg_if.sink    cfg_ch
);

  localparam int AW = $clog2(MAX_DIM);

  logic [CL_W-1:0]  check_length_r;
  logic             advance;
  logic             accept;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [SUM_W-1:0] ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [SUM_W-1:0] ram_rdata;
  stage_t           s2;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_length_r <= CL_RESET;
    end else if (cfg_ch.valid) begin
      check_length_r <= cfg_ch.check_length;
    end
  end

  assign in_ch.ready = advance;
  assign accept      = in_ch.valid && advance;

  pbmc_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_DIM)
  ) u_bound_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pbmc_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .advance         (advance),
    .accept          (accept),
    .action          (in_ch.action),
    .bound_index     (in_ch.bound_index),
    .bound_value     (in_ch.bound_value),
    .coordinate      (in_ch.coordinate),
    .last_coordinate (in_ch.last_coordinate),
    .check_length    (check_length_r),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .ram_re          (ram_re),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata),
    .s2              (s2)
  );

  pbmc_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .s2         (s2),
    .advance    (advance),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_passed (out_ch.vector_passed),
    .out_hits   (out_ch.hit_count),
    .out_trials (out_ch.trial_count)
  );

endmodule
